// ----- sv/hbc_pkg.sv -----
// Package for the hashed block cache: entry layout, operation codes and status codes.
// No dependencies; used by the top level and the checker.
package hbc_pkg;

  typedef struct packed {
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [7:0]  cnt;
    logic        dv;
    logic [31:0] rt;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam logic [1:0] OP_GET     = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_PIN     = 2'd2;
  localparam logic [1:0] OP_UNPIN   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_COUNT   = 2'd2;

  localparam logic [7:0] COUNT_MAX  = 8'hFF;

endpackage

// ----- sv/hbc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module hbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/hashed_block_cache_lru_top.sv -----
// Top level of the hashed block cache tag and replacement engine.
// Depends on hbc_pkg and hbc_ram.
//
// Usage: one request channel (in_valid/in_ready) carries op, device,
// block_number, buffer_handle and now_tick; one result channel
// (out_valid/out_ready) carries status, hit, handle_out and needs_read.
// Every transaction on the request channel gives exactly one result.
// A get first reduces block_number modulo BUCKETS on one shared multiplier
// (reciprocal multiply, then multiply back and subtract), then scans the ways
// of the bucket one at a time through the single read port of the entry RAM,
// reading a way in S_SRD and checking it in S_SCK. A hit ends the scan at its
// way; a miss scans all WAYS ways (eight by default). Release, pin and unpin
// read one entry and rewrite it unless the count check fails; a handle out of
// range is answered without a read. One request is in work at a time;
// in_ready is high only while the engine is idle.
// A finished result sits in an output register, so the next request is
// accepted while the receiver stalls; that request then waits for the output
// register before it finishes. Reset clears the control state and a valid bit
// per entry, so every entry reads as all zero right after reset.
module hashed_block_cache_lru_top #(
  parameter int BUCKETS = 13,
  parameter int WAYS    = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [7:0]  device,
  input  logic [31:0] block_number,
  input  logic [6:0]  buffer_handle,
  input  logic [31:0] now_tick,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        hit,
  output logic [6:0]  handle_out,
  output logic        needs_read
);

  localparam int ENTRIES = BUCKETS * WAYS;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RW      = $clog2(BUCKETS + 1);

  // Reciprocal of BUCKETS scaled by 2^SH, rounded up; exact for every 32-bit block number.
  localparam int          SH       = 32 + $clog2(BUCKETS);
  localparam logic [63:0] RECIP    = ((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam logic [16:0] RECIP_HI = RECIP[32:16];
  localparam logic [16:0] RECIP_LO = {1'b0, RECIP[15:0]};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_BASE = 3'd2;
  localparam logic [2:0] S_SRD  = 3'd3;
  localparam logic [2:0] S_SCK  = 3'd4;
  localparam logic [2:0] S_MISS = 3'd5;
  localparam logic [2:0] S_HCK  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]         state;
  logic [1:0]         req_op;
  logic [7:0]         req_dev;
  logic [31:0]        req_blk;
  logic [31:0]        req_now;
  logic [1:0]         mstep;
  logic [47:0]        prod_lo;
  logic [48:0]        prod_hi;
  logic [31:0]        quo;
  logic [RW-1:0]      rem;
  logic [IDX_W-1:0]   base;
  logic [WAY_W-1:0]   way;
  logic [IDX_W-1:0]   rd_idx;
  logic               have;
  logic [31:0]        best;
  logic [IDX_W-1:0]   victim;
  logic [ENTRIES-1:0] ent_vld;
  logic               rvld;
  logic [1:0]         res_status;
  logic               res_hit;
  logic [6:0]         res_handle;
  logic               res_nr;

  logic                      ram_we;
  logic [IDX_W-1:0]          ram_waddr;
  hbc_pkg::entry_t           ram_wdata;
  logic                      ram_re;
  logic [IDX_W-1:0]          ram_raddr;
  logic [hbc_pkg::ENTRY_W-1:0] ram_rdata;

  hbc_pkg::entry_t  ent;
  logic             match;
  logic             cand;
  logic             accept;
  logic             in_range;
  logic [IDX_W-1:0] hidx;
  logic             h_err;
  hbc_pkg::entry_t  h_new;
  logic [31:0]      mul_a;
  logic [16:0]      mul_b;
  logic [48:0]      mul_p;

  hbc_ram #(
    .WIDTH(hbc_pkg::ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_range = (32'(buffer_handle) < ENTRIES);
  assign hidx     = IDX_W'(buffer_handle);

  assign ent   = rvld ? hbc_pkg::entry_t'(ram_rdata) : '0;
  assign match = (ent.dev == req_dev) && (ent.blk == req_blk);
  assign cand  = (ent.cnt == 8'd0) && (!have || (ent.rt < best));

  always_comb begin
    mul_a = req_blk;
    mul_b = RECIP_LO;
    case (mstep)
      2'd1: begin
        mul_b = RECIP_HI;
      end
      2'd3: begin
        mul_a = quo;
        mul_b = 17'(BUCKETS);
      end
      default: begin
      end
    endcase
  end

  assign mul_p = 49'(mul_a) * 49'(mul_b);

  always_comb begin
    h_new = ent;
    h_err = 1'b0;
    if (req_op == hbc_pkg::OP_PIN) begin
      h_err     = (ent.cnt == hbc_pkg::COUNT_MAX);
      h_new.cnt = ent.cnt + 8'd1;
    end else begin
      h_err     = (ent.cnt == 8'd0);
      h_new.cnt = ent.cnt - 8'd1;
      if ((req_op == hbc_pkg::OP_RELEASE) && (ent.cnt == 8'd1)) begin
        h_new.rt = req_now;
      end
    end
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = hidx;
    ram_we    = 1'b0;
    ram_waddr = rd_idx;
    ram_wdata = ent;
    unique case (state)
      S_IDLE: begin
        ram_re = accept && (op != hbc_pkg::OP_GET) && in_range;
      end
      S_SRD: begin
        ram_re    = 1'b1;
        ram_raddr = base + IDX_W'(way);
      end
      S_SCK: begin
        ram_we        = match && (ent.cnt != hbc_pkg::COUNT_MAX);
        ram_wdata.cnt = ent.cnt + 8'd1;
        ram_wdata.dv  = 1'b1;
      end
      S_MISS: begin
        ram_we        = have;
        ram_waddr     = victim;
        ram_wdata.dev = req_dev;
        ram_wdata.blk = req_blk;
        ram_wdata.cnt = 8'd1;
        ram_wdata.dv  = 1'b1;
        ram_wdata.rt  = best;
      end
      S_HCK: begin
        ram_we    = !h_err;
        ram_wdata = h_new;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      ent_vld   <= '0;
      rvld      <= 1'b0;
    end else begin
      if (ram_re) begin
        rvld <= ent_vld[ram_raddr];
      end
      if (ram_we) begin
        ent_vld[ram_waddr] <= 1'b1;
      end
      if (out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_op  <= op;
            req_dev <= device;
            req_blk <= block_number;
            req_now <= now_tick;
            mstep   <= '0;
            rd_idx  <= hidx;
            if (op == hbc_pkg::OP_GET) begin
              state <= S_MOD;
            end else if (in_range) begin
              state <= S_HCK;
            end else begin
              res_status <= hbc_pkg::ST_OK;
              res_hit    <= 1'b0;
              res_handle <= '0;
              res_nr     <= 1'b0;
              state      <= S_DONE;
            end
          end
        end
        S_MOD: begin
          mstep <= mstep + 2'd1;
          case (mstep)
            2'd0: begin
              prod_lo <= mul_p[47:0];
            end
            2'd1: begin
              prod_hi <= mul_p;
            end
            2'd2: begin
              quo <= 32'(({prod_hi, 16'h0} + 65'(prod_lo)) >> SH);
            end
            default: begin
              rem   <= RW'(req_blk - mul_p[31:0]);
              state <= S_BASE;
            end
          endcase
        end
        S_BASE: begin
          base  <= IDX_W'(int'(rem) * WAYS);
          way   <= '0;
          have  <= 1'b0;
          state <= S_SRD;
        end
        S_SRD: begin
          rd_idx <= ram_raddr;
          state  <= S_SCK;
        end
        S_SCK: begin
          if (match) begin
            res_hit    <= 1'b1;
            res_handle <= 7'(rd_idx);
            if (ent.cnt == hbc_pkg::COUNT_MAX) begin
              res_status <= hbc_pkg::ST_COUNT;
              res_nr     <= 1'b0;
            end else begin
              res_status <= hbc_pkg::ST_OK;
              res_nr     <= !ent.dv;
            end
            state <= S_DONE;
          end else begin
            if (cand) begin
              have   <= 1'b1;
              best   <= ent.rt;
              victim <= rd_idx;
            end
            if (way == WAY_W'(WAYS - 1)) begin
              state <= S_MISS;
            end else begin
              way   <= way + WAY_W'(1);
              state <= S_SRD;
            end
          end
        end
        S_MISS: begin
          res_hit <= 1'b0;
          if (have) begin
            res_status <= hbc_pkg::ST_OK;
            res_handle <= 7'(victim);
            res_nr     <= 1'b1;
          end else begin
            res_status <= hbc_pkg::ST_FULL;
            res_handle <= '0;
            res_nr     <= 1'b0;
          end
          state <= S_DONE;
        end
        S_HCK: begin
          res_status <= h_err ? hbc_pkg::ST_COUNT : hbc_pkg::ST_OK;
          res_hit    <= 1'b0;
          res_handle <= '0;
          res_nr     <= 1'b0;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            status     <= res_status;
            hit        <= res_hit;
            handle_out <= res_handle;
            needs_read <= res_nr;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/hbc_checker.sv -----
// Port-level checker for the hashed block cache, bound to the top level.
// Depends on hbc_pkg and hashed_block_cache_lru_top.
module hbc_checker #(
  parameter int BUCKETS = 13,
  parameter int WAYS    = 8
) (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic       hit,
  input logic [6:0] handle_out,
  input logic       needs_read
);

  localparam int ENTRIES = BUCKETS * WAYS;

  // A stalled result transaction keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(hit)
      && $stable(handle_out) && $stable(needs_read))
    else $error("result changed while stalled");

  // A full bucket reports nothing else.
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == hbc_pkg::ST_FULL) |-> !hit && (handle_out == 7'd0) && !needs_read)
    else $error("full status with nonzero fields");

  // A count error, from a get hit or a handle operation, never requests a disk read.
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == hbc_pkg::ST_COUNT) |-> !needs_read)
    else $error("count error with needs_read");

  // A read is requested only with an OK status.
  a_nr: assert property (@(posedge clk) disable iff (rst)
    out_valid && needs_read |-> (status == hbc_pkg::ST_OK))
    else $error("needs_read with bad status");

  // A given handle names an existing buffer.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ENTRIES > 128) || (32'(handle_out) < ENTRIES))
    else $error("handle out of range");

endmodule

bind hashed_block_cache_lru_top hbc_checker #(
  .BUCKETS(BUCKETS),
  .WAYS(WAYS)
) u_hbc_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status),
  .hit        (hit),
  .handle_out (handle_out),
  .needs_read (needs_read)
);
